/* rtl/ordered_list_engine_defines.svh */
// ----------------------------------------------------------------------------
// ordered_list_engine_defines
// assertion helpers for the ordered list engine rtl
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define OLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define OLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ole_pkg.sv */
// ----------------------------------------------------------------------------
// ole_pkg
// types, codes and constants of the ordered list engine
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

    localparam int OLE_CAPACITY = 1024;
    localparam int FUNC_W       = 3;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 11;
    localparam int STATUS_W     = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT    = 3'd0,
        FUNC_POP_FRONT = 3'd1,
        FUNC_POP_BACK  = 3'd2,
        FUNC_DELETE    = 3'd3,
        FUNC_FIND      = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    // which walk over the store a request needs
    typedef enum logic [1:0] {
        ROUTE_NONE,
        ROUTE_UP,
        ROUTE_DOWN
    } route_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_UP,
        ST_DOWN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic run;
        logic dir_down;
        logic commit;
    } cmd_t;

    typedef struct packed {
        route_t route;
        logic   walk_done;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/ole_ctrl.sv */
// ----------------------------------------------------------------------------
// ole_ctrl
// sequencer for the ordered list engine: handshakes and walk control
// ----------------------------------------------------------------------------
`default_nettype none

module ole_ctrl
    import ole_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                unique case (sts.route)
                    ROUTE_UP:   state_next = ST_UP;
                    ROUTE_DOWN: state_next = ST_DOWN;
                    default:    state_next = ST_FIN;
                endcase
            end
            ST_UP, ST_DOWN:
            begin
                if (sts.walk_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait until the result register is free
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd.load     = in_valid && (state_reg == ST_IDLE);
        cmd.start    = (state_reg == ST_DECIDE);
        cmd.run      = (state_reg == ST_UP) || (state_reg == ST_DOWN);
        cmd.dir_down = (state_reg == ST_DOWN);
        cmd.commit   = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/ole_datapath.sv */
// ----------------------------------------------------------------------------
// ole_datapath
// entry store, walk pointers, request latch and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module ole_datapath
    import ole_pkg::*;
#(
    parameter int CAPACITY = OLE_CAPACITY
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cmd_t                       cmd,
    output sts_t                            sts,
    input  wire logic [FUNC_W-1:0]          in_func,
    input  wire logic signed [VALUE_W-1:0]  in_value,
    input  wire logic [POS_W-1:0]           in_position,
    output logic [STATUS_W-1:0]             res_status,
    output logic                            res_found,
    output logic [POS_W-1:0]                res_removed,
    output logic [POS_W-1:0]                res_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [VALUE_W-1:0] mem [CAPACITY];

    logic [FUNC_W-1:0]  req_func_reg;
    logic [VALUE_W-1:0] req_value_reg;
    logic [POS_W-1:0]   req_pos_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic [CW-1:0]      left_reg;
    logic               pend_reg;
    logic [AW-1:0]      pend_idx_reg;
    logic [CW-1:0]      kept_reg;
    logic               found_reg;
    logic [VALUE_W-1:0] rdata_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic                res_found_reg;
    logic [POS_W-1:0]    res_removed_reg;
    logic [POS_W-1:0]    res_count_reg;

    logic               range_err;
    logic               full;
    logic               empty;
    logic               ins_ok;
    logic               rd_en;
    logic               keep;
    logic               hit;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    route_t             route;

    status_t            st_new;
    logic [CW-1:0]      cnt_new;
    logic [CW-1:0]      rem_new;
    logic               fnd_new;

    assign range_err = PW'(req_pos_reg) > PW'(count_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign ins_ok    = !range_err && !full;
    assign rd_en     = cmd.run && (left_reg != '0);
    assign keep      = (req_func_reg == FUNC_POP_FRONT) ||
                       ((req_func_reg == FUNC_DELETE) && (rdata_reg != req_value_reg));
    assign hit       = (req_func_reg == FUNC_FIND) && (rdata_reg == req_value_reg);

    always_comb
    begin
        unique case (req_func_reg) inside
            FUNC_INSERT:            route = ins_ok ? ROUTE_DOWN : ROUTE_NONE;
            FUNC_POP_FRONT:         route = empty ? ROUTE_NONE : ROUTE_UP;
            FUNC_DELETE, FUNC_FIND: route = ROUTE_UP;
            default:                route = ROUTE_NONE;
        endcase
    end

    assign sts.route     = route;
    assign sts.walk_done = (left_reg == '0) && !pend_reg;

    // one write port: final insert write, shift write or compaction write
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = kept_reg[AW-1:0];
        wr_data = rdata_reg;
        if (cmd.commit && (req_func_reg == FUNC_INSERT) && ins_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(req_pos_reg);
            wr_data = req_value_reg;
        end
        else if (cmd.run && pend_reg)
        begin
            if (cmd.dir_down)
            begin
                wr_en   = 1'b1;
                wr_addr = pend_idx_reg + AW'(1);
            end
            else if (keep)
            begin
                wr_en = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= mem[rd_idx_reg];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // result of the request at commit
    always_comb
    begin
        st_new  = STAT_OK;
        cnt_new = count_reg;
        rem_new = '0;
        fnd_new = 1'b0;
        unique case (req_func_reg) inside
            FUNC_INSERT:
            begin
                if (range_err)
                    st_new = STAT_RANGE;
                else if (full)
                    st_new = STAT_FULL;
                else
                    cnt_new = count_reg + CW'(1);
            end
            FUNC_POP_FRONT, FUNC_DELETE:
            begin
                if (empty && (req_func_reg == FUNC_POP_FRONT))
                    st_new = STAT_EMPTY;
                else
                begin
                    cnt_new = kept_reg;
                    rem_new = count_reg - kept_reg;
                end
            end
            FUNC_POP_BACK:
            begin
                if (empty)
                    st_new = STAT_EMPTY;
                else
                begin
                    cnt_new = count_reg - CW'(1);
                    rem_new = CW'(1);
                end
            end
            FUNC_FIND: fnd_new = found_reg;
            default:   st_new  = STAT_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                pend_reg <= 1'b0;
                if (route == ROUTE_DOWN)
                    left_reg <= count_reg - CW'(req_pos_reg);
                else if ((route == ROUTE_UP) && (req_func_reg == FUNC_POP_FRONT))
                    left_reg <= count_reg - CW'(1);
                else
                    left_reg <= count_reg;
            end
            else if (cmd.run)
            begin
                pend_reg <= rd_en;
                if (rd_en)
                    left_reg <= left_reg - CW'(1);
            end
            if (cmd.commit)
                count_reg <= cnt_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_func_reg  <= in_func;
            req_value_reg <= in_value;
            req_pos_reg   <= in_position;
        end
        if (cmd.start)
        begin
            kept_reg  <= '0;
            found_reg <= 1'b0;
            if (route == ROUTE_DOWN)
                rd_idx_reg <= AW'(count_reg - CW'(1));
            else if (req_func_reg == FUNC_POP_FRONT)
                rd_idx_reg <= AW'(1);
            else
                rd_idx_reg <= '0;
        end
        else if (cmd.run)
        begin
            if (rd_en)
            begin
                pend_idx_reg <= rd_idx_reg;
                if (cmd.dir_down)
                    rd_idx_reg <= rd_idx_reg - AW'(1);
                else
                    rd_idx_reg <= rd_idx_reg + AW'(1);
            end
            if (pend_reg && !cmd.dir_down)
            begin
                if (keep)
                    kept_reg <= kept_reg + CW'(1);
                if (hit)
                    found_reg <= 1'b1;
            end
        end
        if (cmd.commit)
        begin
            res_status_reg  <= st_new;
            res_found_reg   <= fnd_new;
            res_removed_reg <= POS_W'(rem_new);
            res_count_reg   <= POS_W'(cnt_new);
        end
    end

    assign res_status  = res_status_reg;
    assign res_found   = res_found_reg;
    assign res_removed = res_removed_reg;
    assign res_count   = res_count_reg;

endmodule

`default_nettype wire

/* rtl/ordered_list_engine.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine
// bounded ordered list of signed 32-bit values with insert, pop, delete, find
// ----------------------------------------------------------------------------
// One request is worked at a time and gives one result transaction. Entries
// sit packed in a single-port-write, single-port-read memory and are moved one
// per cycle. An insert shifts count - position entries toward the back, a pop
// front moves count - 1 entries, and delete-all-equal and find make one pass
// front to back over all count entries. Pop back, pops of an empty list,
// rejected inserts and ignored codes walk no entries. A new request is taken
// while the previous result still waits in the output register; the new one
// then holds in its last cycle until that result is taken. The store needs no
// clearing after reset: only the first count entries are ever read.
`default_nettype none

`include "ordered_list_engine_defines.svh"

module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int CAPACITY = OLE_CAPACITY
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [FUNC_W-1:0]         func,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic [POS_W-1:0]          position,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [STATUS_W-1:0]            status,
    output logic                           found,
    output logic [POS_W-1:0]               removed,
    output logic [POS_W-1:0]               count
);

    cmd_t cmd;
    sts_t sts;

    ole_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ole_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_func     (func),
        .in_value    (value),
        .in_position (position),
        .res_status  (status),
        .res_found   (found),
        .res_removed (removed),
        .res_count   (count)
    );

    `OLE_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready,
        "request accepted while another is in flight")
    `OLE_ASSERT_IMP(a_err_removes_none, clk, rst_n, out_valid && (status != STAT_OK),
        removed == '0, "failed request reports removed entries")
    `OLE_ASSERT_IMP(a_found_clean, clk, rst_n, out_valid && found,
        (status == STAT_OK) && (removed == '0), "find result carries error or removal")
    `OLE_ASSERT_IMP(a_count_bound, clk, rst_n, out_valid,
        32'(count) <= 32'(CAPACITY), "count beyond capacity")

endmodule

`default_nettype wire

/* sim/ordered_list_engine_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_test
// self-checking bench for the ordered list engine
// ----------------------------------------------------------------------------
// Requests go in through the valid/ready input channel while a shadow copy of
// the list works out the outcome of each one. Every result transaction is
// checked field by field against the oldest outcome still awaited. The run
// covers an empty list, small hand-built edits, a store filled to capacity,
// and a long random mix of requests with gaps on the input side and stalls
// on the result side.
// ----------------------------------------------------------------------------

module ordered_list_engine_test;
    import ole_pkg::*;

    localparam int RANDOM_ITEMS = 580;
    localparam int CALM_ITEMS   = 100;
    localparam int DRAIN_CYCLES = OLE_CAPACITY + 64;
    localparam int MAX_PRINTED  = 40;

    // func codes the block ignores
    localparam logic [FUNC_W-1:0] FUNC_IGNORED_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_IGNORED_LAST  = 3'd7;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] FILL_VALUE = 32'sd42;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [POS_W-1:0] removed;
        logic [POS_W-1:0] count;
    } list_outcome_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic                      out_valid;
    logic                      out_ready;
    logic [STATUS_W-1:0]       status;
    logic                      found;
    logic [POS_W-1:0]          removed;
    logic [POS_W-1:0]          count;

    // shadow copy of the list
    logic signed [VALUE_W-1:0] list_entries [OLE_CAPACITY];
    int                        list_len;

    list_outcome_t awaited_outcomes [$];
    int unsigned   mismatch_count;
    bit            idle_on;

    ordered_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .found     (found),
        .removed   (removed),
        .count     (count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic list_outcome_t apply_list_op(
        input logic [FUNC_W-1:0]         f,
        input logic signed [VALUE_W-1:0] v,
        input logic [POS_W-1:0]          p
    );
        list_outcome_t res;
        int            kept;
        res = '{status: STAT_OK, found: 1'b0, removed: '0, count: '0};
        case (f)
            FUNC_INSERT:
            begin
                // range check wins over the full check
                if (int'(p) > list_len)
                    res.status = STAT_RANGE;
                else if (list_len >= OLE_CAPACITY)
                    res.status = STAT_FULL;
                else
                begin
                    for (int i = list_len; i > int'(p); i--)
                        list_entries[i] = list_entries[i - 1];
                    list_entries[p] = v;
                    list_len++;
                end
            end
            FUNC_POP_FRONT:
            begin
                if (list_len == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    for (int i = 0; i + 1 < list_len; i++)
                        list_entries[i] = list_entries[i + 1];
                    list_len--;
                    res.removed = 1;
                end
            end
            FUNC_POP_BACK:
            begin
                if (list_len == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    list_len--;
                    res.removed = 1;
                end
            end
            FUNC_DELETE:
            begin
                kept = 0;
                for (int i = 0; i < list_len; i++)
                begin
                    if (list_entries[i] !== v)
                    begin
                        list_entries[kept] = list_entries[i];
                        kept++;
                    end
                end
                res.removed = POS_W'(list_len - kept);
                list_len = kept;
            end
            FUNC_FIND:
            begin
                for (int i = 0; i < list_len; i++)
                    if (list_entries[i] === v)
                        res.found = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.count = POS_W'(list_len);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint exp_val,
                                   input longint got_val);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t: mismatch on %s: expected %0d, got %0d",
                     $realtime, what, exp_val, got_val);
        mismatch_count++;
    endtask

    // one request transaction; the outcome is predicted at the accepting edge
    task automatic send_request(input logic [FUNC_W-1:0]         f,
                                input logic signed [VALUE_W-1:0] v,
                                input logic [POS_W-1:0]          p);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        value    <= v;
        position <= p;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        awaited_outcomes.push_back(apply_list_op(f, v, p));
    endtask

    function automatic logic signed [VALUE_W-1:0] pool_value(input int idx);
        case (idx)
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return '0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            5:       return 32'sh5555_5555;
            6:       return 32'shaaaa_aaaa;
            default: return FILL_VALUE;
        endcase
    endfunction

    task automatic test_empty_list();
        send_request(FUNC_POP_FRONT, VALUE_MAX, '0);
        send_request(FUNC_POP_BACK, VALUE_MIN, '1);
        send_request(FUNC_DELETE, '0, '0);
        send_request(FUNC_FIND, '0, '0);
        send_request(FUNC_INSERT, 32'sd3, 11'd1);
        send_request(FUNC_INSERT, 32'sd3, '1);
        for (int f = FUNC_IGNORED_FIRST; f <= FUNC_IGNORED_LAST; f++)
            send_request(FUNC_W'(f), '1, '1);
    endtask

    task automatic test_small_edits();
        // one-entry list popped from either end
        send_request(FUNC_INSERT, 32'sd5, '0);
        send_request(FUNC_POP_FRONT, '0, '0);
        send_request(FUNC_INSERT, VALUE_MAX, '0);
        send_request(FUNC_POP_BACK, '0, '0);
        // front, back and middle inserts with duplicates
        send_request(FUNC_INSERT, -32'sd1, '0);
        send_request(FUNC_INSERT, VALUE_MIN, POS_W'(list_len));
        send_request(FUNC_INSERT, '0, '0);
        send_request(FUNC_INSERT, -32'sd1, 11'd1);
        send_request(FUNC_INSERT, VALUE_MAX, POS_W'(list_len));
        send_request(FUNC_INSERT, -32'sd1, 11'd2);
        send_request(FUNC_INSERT, 32'sd9, POS_W'(list_len + 1));
        send_request(FUNC_FIND, -32'sd1, '0);
        send_request(FUNC_FIND, 32'sd1234, '0);
        send_request(FUNC_FIND, VALUE_MIN, '0);
        send_request(FUNC_DELETE, -32'sd1, '0);
        send_request(FUNC_DELETE, 32'sd1234, '0);
        send_request(FUNC_POP_FRONT, '0, '0);
        while (list_len > 0)
            send_request(FUNC_POP_BACK, '0, '0);
    endtask

    task automatic test_full_store();
        while (list_len < OLE_CAPACITY)
        begin
            if (list_len == OLE_CAPACITY / 2)
                send_request(FUNC_INSERT, VALUE_MAX, POS_W'(list_len / 2));
            else
                send_request(FUNC_INSERT, FILL_VALUE, POS_W'(list_len));
        end
        send_request(FUNC_FIND, VALUE_MAX, '0);
        send_request(FUNC_DELETE, VALUE_MAX, '0);
        send_request(FUNC_INSERT, FILL_VALUE, POS_W'(list_len));
        // position equal to count on a full store reports full, not range
        send_request(FUNC_INSERT, 32'sd7, POS_W'(OLE_CAPACITY));
        send_request(FUNC_INSERT, 32'sd7, POS_W'(OLE_CAPACITY + 1));
        send_request(FUNC_INSERT, 32'sd7, '1);
        send_request(FUNC_INSERT, 32'sd7, '0);
        send_request(FUNC_FIND, FILL_VALUE + 1, '0);
        send_request(FUNC_POP_FRONT, '0, '0);
        send_request(FUNC_INSERT, FILL_VALUE, '0);
        send_request(FUNC_FIND, FILL_VALUE, '0);
        send_request(FUNC_DELETE, FILL_VALUE, '0);
    endtask

    task automatic test_random_mix();
        int                        counted;
        int                        insert_odds;
        int                        pick;
        logic [FUNC_W-1:0]         f;
        logic signed [VALUE_W-1:0] v;
        logic [POS_W-1:0]          p;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            idle_on = (counted < RANDOM_ITEMS - CALM_ITEMS);
            // steer the list length toward a few dozen entries
            insert_odds = (list_len < 20) ? 70 : (list_len < 60) ? 50 : 30;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                f = FUNC_W'($urandom_range(FUNC_IGNORED_FIRST, FUNC_IGNORED_LAST));
            else if (pick < insert_odds)
                f = FUNC_INSERT;
            else
            begin
                case ($urandom_range(0, 5))
                    0:       f = FUNC_POP_FRONT;
                    1:       f = FUNC_POP_BACK;
                    2, 3:    f = FUNC_DELETE;
                    default: f = FUNC_FIND;
                endcase
            end

            case ($urandom_range(0, 9))
                0, 1, 2: v = $urandom;
                3, 4, 5: v = pool_value($urandom_range(0, 7));
                default: v = (list_len > 0) ?
                             list_entries[$urandom_range(0, list_len - 1)] : $urandom;
            endcase

            if (f == FUNC_INSERT)
            begin
                case ($urandom_range(0, 19))
                    0:       p = POS_W'($urandom_range(list_len + 1, 2047));
                    1:       p = '0;
                    2:       p = POS_W'(list_len);
                    default: p = POS_W'($urandom_range(0, list_len));
                endcase
            end
            else
                p = POS_W'($urandom_range(0, 2047));

            send_request(f, v, p);
            if (f <= FUNC_FIND)
                counted++;
        end
    endtask

    // result side: random stall bursts, none while idling is off
    initial
    begin
        out_ready <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        list_outcome_t exp;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (awaited_outcomes.size() == 0)
                report_mismatch("result with none awaited", 0, 1);
            else
            begin
                exp = awaited_outcomes.pop_front();
                if (status !== exp.status)
                    report_mismatch("status", exp.status, status);
                if (found !== exp.found)
                    report_mismatch("found", exp.found, found);
                if (removed !== exp.removed)
                    report_mismatch("removed", exp.removed, removed);
                if (count !== exp.count)
                    report_mismatch("count", exp.count, count);
            end
        end
    end

    initial
    begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        mismatch_count = 0;
        list_len       = 0;
        idle_on        = 1'b1;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        func     <= '0;
        value    <= '0;
        position <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_small_edits();
        test_full_store();
        test_random_mix();
        in_valid <= 1'b0;

        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/ole_pkg.sv
rtl/ole_ctrl.sv
rtl/ole_datapath.sv
rtl/ordered_list_engine.sv
sim/ordered_list_engine_test.sv
